// ===== sv/pcc_pkg.sv =====
// Shared types, constants and root-prefix tables for the path confinement checker.
package pcc_pkg;

	localparam int unsigned QueueDepth = 4;
	localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
	localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

	localparam logic [7:0] MaxLenReset = 8'd127;
	localparam logic [7:0] CharSlash   = 8'h2F;
	localparam logic [7:0] CharDot     = 8'h2E;
	localparam logic [7:0] CharSpace   = 8'h20;
	localparam logic [7:0] CharDel     = 8'h7F;
	localparam logic [7:0] CountMax    = 8'd255;

	localparam logic [7:0] AppsLen   = 8'd6;
	localparam logic [7:0] AssetsLen = 8'd8;

	// Register indexes (word addresses on the configuration port)
	localparam logic [0:0] RegMaxPathLen = 1'b0;

	typedef struct packed {
		logic [7:0] char;
		logic       is_term;
		logic       is_slash;
		logic       is_dot;
		logic       is_illegal;
	} pcc_item_t;

	typedef struct packed {
		logic pop;
		logic pop_term;
	} pcc_back_stat_t;

	function automatic logic [7:0] apps_root_char(input logic [2:0] idx);
		logic [7:0] c;
		case (idx)
			3'd0:    c = 8'h2F;
			3'd1:    c = 8'h61;
			3'd2:    c = 8'h70;
			3'd3:    c = 8'h70;
			3'd4:    c = 8'h73;
			3'd5:    c = 8'h2F;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	function automatic logic [7:0] assets_root_char(input logic [2:0] idx);
		logic [7:0] c;
		case (idx)
			3'd0:    c = 8'h2F;
			3'd1:    c = 8'h61;
			3'd2:    c = 8'h73;
			3'd3:    c = 8'h73;
			3'd4:    c = 8'h65;
			3'd5:    c = 8'h74;
			3'd6:    c = 8'h73;
			3'd7:    c = 8'h2F;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

endpackage

// ===== sv/path_confinement_check.sv =====
// Top level of the path confinement checker: configuration port, front end, queue, back end.
//
//   channel   | signals                                 | direction
//   ----------+-----------------------------------------+----------
//   bytes     | byte_valid, byte_stall, path_byte[7:0]  | in
//   verdict   | verdict_valid, verdict_stall, path_ok   | out
//   config    | psel, penable, pwrite, paddr, pwdata... | APB slave
//
// One byte per cycle while the queue has room; the back end retires one queued byte per cycle
// unless a terminator waits for the output slot; verdicts leave via the output register.
// Reset sets max_path_len to 127 and clears all per-path state; no clearing pass.
// A stalled verdict holds the output register; bytes keep flowing until the
// four-entry queue and the front register fill behind a waiting terminator.
module path_confinement_check import pcc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        byte_valid,
	output logic        byte_stall,
	input  logic [7:0]  path_byte,
	output logic        verdict_valid,
	input  logic        verdict_stall,
	output logic        path_ok
);

	logic [7:0]           max_path_len_q;
	logic                 push_valid;
	logic                 push_ready;
	pcc_item_t            push_item;
	logic                 pop_valid;
	logic                 pop;
	pcc_item_t            pop_item;
	logic [QueueCntW-1:0] fill;
	pcc_back_stat_t       stat;
	logic                 reg_sel;

	assign pready  = 1'b1;
	assign reg_sel = (paddr[2] == RegMaxPathLen);
	assign prdata  = reg_sel ? {24'd0, max_path_len_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_path_len_q <= MaxLenReset;
		end else if (psel && penable && pwrite && pready && reg_sel) begin
			max_path_len_q <= pwdata[7:0];
		end
	end

	pcc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_stall (byte_stall),
		.path_byte  (path_byte),
		.push_ready (push_ready),
		.push_valid (push_valid),
		.push_item  (push_item)
	);

	pcc_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item),
		.pop_valid  (pop_valid),
		.pop        (pop),
		.pop_item   (pop_item),
		.fill       (fill)
	);

	pcc_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.max_path_len  (max_path_len_q),
		.pop_valid     (pop_valid),
		.pop_item      (pop_item),
		.pop           (pop),
		.stat          (stat),
		.verdict_valid (verdict_valid),
		.verdict_stall (verdict_stall),
		.path_ok       (path_ok)
	);

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill <= QueueCntW'(QueueDepth))
		else $error("queue fill beyond depth");

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		byte_stall |-> (push_valid && (fill == QueueCntW'(QueueDepth))))
		else $error("byte channel stalled while queue has room");

	a_term_gives_verdict: assert property (@(posedge clk) disable iff (!arst_n)
		stat.pop_term |=> verdict_valid)
		else $error("terminator retired without a verdict");

	a_term_needs_slot: assert property (@(posedge clk) disable iff (!arst_n)
		stat.pop_term |-> (!verdict_valid || !verdict_stall))
		else $error("verdict overwritten while stalled");

endmodule

// ===== sv/pcc_front.sv =====
// Front end: accepts path bytes, classifies them and hands them to the queue.
module pcc_front import pcc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      byte_valid,
	output logic      byte_stall,
	input  logic [7:0] path_byte,
	input  logic      push_ready,
	output logic      push_valid,
	output pcc_item_t push_item
);

	logic      valid_s1;
	pcc_item_t item_s1;
	pcc_item_t item_cls;
	logic      accept;

	always_comb begin
		item_cls.char       = path_byte;
		item_cls.is_term    = (path_byte == 8'h00);
		item_cls.is_slash   = (path_byte == CharSlash);
		item_cls.is_dot     = (path_byte == CharDot);
		item_cls.is_illegal = (path_byte <= CharSpace) || (path_byte == CharDel);
	end

	assign byte_stall = valid_s1 && !push_ready;
	assign accept     = byte_valid && !byte_stall;
	assign push_valid = valid_s1;
	assign push_item  = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (push_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item_cls;
		end
	end

endmodule

// ===== sv/pcc_queue.sv =====
// Short queue of classified bytes between the front end and the back end.
module pcc_queue import pcc_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push_valid,
	output logic                 push_ready,
	input  pcc_item_t            push_item,
	output logic                 pop_valid,
	input  logic                 pop,
	output pcc_item_t            pop_item,
	output logic [QueueCntW-1:0] fill
);

	pcc_item_t             mem_q [QueueDepth];
	logic [QueuePtrW-1:0]  wr_ptr_q;
	logic [QueuePtrW-1:0]  rd_ptr_q;
	logic [QueueCntW-1:0]  count_q;
	logic                  do_push;
	logic                  do_pop;

	assign push_ready = (count_q != QueueCntW'(QueueDepth));
	assign do_push    = push_valid && push_ready;
	assign pop_valid  = (count_q != '0);
	assign do_pop     = pop && pop_valid;
	assign pop_item   = mem_q[rd_ptr_q];
	assign fill       = count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

// ===== sv/pcc_back.sv =====
// Back end: per-path rule state, verdict on the terminator and the output register.
module pcc_back import pcc_pkg::*; (
	input  logic           clk,
	input  logic           arst_n,
	input  logic [7:0]     max_path_len,
	input  logic           pop_valid,
	input  pcc_item_t      pop_item,
	output logic           pop,
	output pcc_back_stat_t stat,
	output logic           verdict_valid,
	input  logic           verdict_stall,
	output logic           path_ok
);

	logic [7:0] byte_count_q;
	logic       apps_alive_q;
	logic       assets_alive_q;
	logic       root_matched_q;
	logic       rejected_q;
	logic [1:0] seg_len_q;
	logic       seg_all_dots_q;
	logic       last_slash_q;
	logic       out_valid_q;
	logic       path_ok_q;

	logic       out_free;
	logic       seg_bad;
	logic       verdict;
	logic       apps_hit;
	logic       assets_hit;
	logic       reject_now;

	assign out_free = !out_valid_q || !verdict_stall;
	// Ordinary bytes never need the output slot; only the terminator waits for it.
	assign pop      = pop_valid && (!pop_item.is_term || out_free);
	assign stat     = '{pop: pop, pop_term: pop && pop_item.is_term};

	assign seg_bad = (seg_len_q == 2'd0) || ((seg_len_q <= 2'd2) && seg_all_dots_q);
	assign verdict = (byte_count_q != 8'd0) && !rejected_q && root_matched_q &&
			!last_slash_q && !seg_bad;

	assign apps_hit   = (pop_item.char == apps_root_char(byte_count_q[2:0]));
	assign assets_hit = (pop_item.char == assets_root_char(byte_count_q[2:0]));
	assign reject_now = (byte_count_q >= max_path_len) || pop_item.is_illegal ||
			(pop_item.is_slash && (byte_count_q != 8'd0) && seg_bad);

	assign verdict_valid = out_valid_q;
	assign path_ok       = path_ok_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_count_q   <= '0;
			apps_alive_q   <= 1'b1;
			assets_alive_q <= 1'b1;
			root_matched_q <= 1'b0;
			rejected_q     <= 1'b0;
			seg_len_q      <= '0;
			seg_all_dots_q <= 1'b1;
			last_slash_q   <= 1'b0;
			out_valid_q    <= 1'b0;
		end else begin
			if (out_valid_q && !verdict_stall) begin
				out_valid_q <= 1'b0;
			end
			if (pop && pop_item.is_term) begin
				out_valid_q    <= 1'b1;
				byte_count_q   <= '0;
				apps_alive_q   <= 1'b1;
				assets_alive_q <= 1'b1;
				root_matched_q <= 1'b0;
				rejected_q     <= 1'b0;
				seg_len_q      <= '0;
				seg_all_dots_q <= 1'b1;
				last_slash_q   <= 1'b0;
			end else if (pop) begin
				if (reject_now) rejected_q <= 1'b1;
				if (byte_count_q < AppsLen) begin
					if (!apps_hit) begin
						apps_alive_q <= 1'b0;
					end else if (byte_count_q == AppsLen - 8'd1 && apps_alive_q) begin
						root_matched_q <= 1'b1;
					end
				end
				if (byte_count_q < AssetsLen) begin
					if (!assets_hit) begin
						assets_alive_q <= 1'b0;
					end else if (byte_count_q == AssetsLen - 8'd1 && assets_alive_q) begin
						root_matched_q <= 1'b1;
					end
				end
				if (pop_item.is_slash) begin
					seg_len_q      <= '0;
					seg_all_dots_q <= 1'b1;
					last_slash_q   <= 1'b1;
				end else begin
					if (seg_len_q != 2'd3) seg_len_q <= seg_len_q + 2'd1;
					if (!pop_item.is_dot) seg_all_dots_q <= 1'b0;
					last_slash_q <= 1'b0;
				end
				if (byte_count_q != CountMax) byte_count_q <= byte_count_q + 8'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && pop_item.is_term) begin
			path_ok_q <= verdict;
		end
	end

endmodule
